// File: design/mach_scheduled_accel_limiter_defines.svh
// assertion macros for the mach scheduled acceleration limiter
`ifndef MACH_SCHEDULED_ACCEL_LIMITER_DEFINES_SVH
`define MACH_SCHEDULED_ACCEL_LIMITER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MSAL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("msal: same-cycle check failed");

// next-cycle implication, checked outside reset
`define MSAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("msal: next-cycle check failed");

`endif

// File: design/msal_pkg.sv
// shared types, limit tables and widths for the acceleration limiter
`timescale 1ns / 1ps

package msal_pkg;

	// table size, forced into the supported range
	localparam int TABLE_POINTS = 6;
	localparam int SLOT_COUNT   = 16;
	localparam int PT_N = (TABLE_POINTS < 2) ? 2 :
		((TABLE_POINTS > SLOT_COUNT) ? SLOT_COUNT : TABLE_POINTS);
	localparam int IDX_W = $clog2(SLOT_COUNT);

	// datapath widths
	localparam int MACH_W = 16;
	localparam int ACC_W  = 16;
	localparam int D_W    = 16;
	localparam int RCP_W  = 21;
	localparam int MAG_W  = 12;
	localparam int DR_W   = 31;
	localparam int PROD_W = MAG_W + DR_W;
	localparam int FRAC_SH = 30;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [MACH_W-1:0] mach_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	// mach breakpoints, Q2.14
	localparam mach_t BP_TAB [SLOT_COUNT] = '{
		16'd6554, 16'd9830, 16'd13107, 16'd15565, 16'd17203, 16'd18022,
		16'd18022, 16'd18022, 16'd18022, 16'd18022, 16'd18022, 16'd18022,
		16'd18022, 16'd18022, 16'd18022, 16'd18022
	};

	// upper limits, Q8.8
	localparam acc_t UP_TAB [SLOT_COUNT] = '{
		16'sd128, 16'sd512, 16'sd768, 16'sd2560, 16'sd3072, 16'sd3840,
		16'sd3840, 16'sd3840, 16'sd3840, 16'sd3840, 16'sd3840, 16'sd3840,
		16'sd3840, 16'sd3840, 16'sd3840, 16'sd3840
	};

	// lower limits, Q8.8
	localparam acc_t LO_TAB [SLOT_COUNT] = '{
		-16'sd77, -16'sd256, -16'sd512, -16'sd2048, -16'sd2560, -16'sd3328,
		-16'sd3328, -16'sd3328, -16'sd3328, -16'sd3328, -16'sd3328, -16'sd3328,
		-16'sd3328, -16'sd3328, -16'sd3328, -16'sd3328
	};

	// per-segment rounded reciprocal of the breakpoint gap, scaled by 2^30
	// zero where the gap is zero
	localparam logic [RCP_W-1:0] RCP_TAB [SLOT_COUNT] = '{
		21'd327760, 21'd327660, 21'd436836, 21'd655520, 21'd1311040, 21'd0,
		21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0,
		21'd0, 21'd0, 21'd0, 21'd0
	};

	// global bounds any limit can take
	localparam acc_t LIM_MAX = 16'sd3840;
	localparam acc_t LIM_MIN = -16'sd3328;

	// one limit: segment base, slope sign and slope magnitude
	typedef struct packed {
		acc_t             base;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} lim_seg_t;

	// word after segment lookup
	typedef struct packed {
		lim_seg_t         up;
		lim_seg_t         lo;
		logic [D_W-1:0]   d;
		logic [RCP_W-1:0] rcp;
		acc_t             cmd;
	} lk_word_t;

	// word holding the interpolated limits
	typedef struct packed {
		acc_t upper;
		acc_t lower;
		acc_t cmd;
	} lim_word_t;

endpackage

// File: design/msal_if.sv
// stream interfaces for the limiter input and result channels
`timescale 1ns / 1ps

interface msal_in_if;
	logic               valid;
	logic               ready;
	logic        [15:0] mach;
	logic signed [15:0] pitch_accel;

	modport source (output valid, output mach, output pitch_accel, input ready);
	modport sink (input valid, input mach, input pitch_accel, output ready);
endinterface

interface msal_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] limited_accel;

	modport source (output valid, output limited_accel, input ready);
	modport sink (input valid, input limited_accel, output ready);
endinterface

// File: design/msal_lookup.sv
// segment search and table lookup stage
`timescale 1ns / 1ps

module msal_lookup (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_i,
	output logic              ready_o,
	input  msal_pkg::mach_t   mach,
	input  msal_pkg::acc_t    cmd,
	output logic              valid_o,
	input  logic              ready_i,
	output msal_pkg::lk_word_t word_o
);
	import msal_pkg::*;

	logic     sat_lo;
	logic     sat_hi;
	idx_t     seg;
	idx_t     seg_nx;
	idx_t     idx;
	lk_word_t lk_d;
	logic signed [ACC_W:0] up_delta;
	logic signed [ACC_W:0] lo_delta;
	logic signed [ACC_W:0] up_abs;
	logic signed [ACC_W:0] lo_abs;
	logic     v_s1;
	lk_word_t lk_s1;

	// last breakpoint at or below the mach number
	always_comb begin
		seg = '0;
		for (int i = 0; i < PT_N - 1; i++) begin
			if (BP_TAB[i] <= mach) begin
				seg = IDX_W'(i);
			end
		end
	end

	assign sat_lo = (mach <= BP_TAB[0]);
	assign sat_hi = (mach >= BP_TAB[PT_N-1]);
	assign seg_nx = seg + 1'b1;

	// slopes of both limits across the segment
	assign up_delta = {UP_TAB[seg_nx][ACC_W-1], UP_TAB[seg_nx]}
		- {UP_TAB[seg][ACC_W-1], UP_TAB[seg]};
	assign lo_delta = {LO_TAB[seg_nx][ACC_W-1], LO_TAB[seg_nx]}
		- {LO_TAB[seg][ACC_W-1], LO_TAB[seg]};
	assign up_abs = up_delta[ACC_W] ? -up_delta : up_delta;
	assign lo_abs = lo_delta[ACC_W] ? -lo_delta : lo_delta;

	// pick base entry and slope, flat outside the table
	always_comb begin
		lk_d.cmd = cmd;
		if (sat_lo || sat_hi) begin
			idx = sat_lo ? '0 : IDX_W'(PT_N - 1);
			lk_d.up.base = UP_TAB[idx];
			lk_d.up.neg  = 1'b0;
			lk_d.up.mag  = '0;
			lk_d.lo.base = LO_TAB[idx];
			lk_d.lo.neg  = 1'b0;
			lk_d.lo.mag  = '0;
			lk_d.d       = '0;
			lk_d.rcp     = '0;
		end else begin
			idx = seg;
			lk_d.up.base = UP_TAB[idx];
			lk_d.up.neg  = up_delta[ACC_W];
			lk_d.up.mag  = up_abs[MAG_W-1:0];
			lk_d.lo.base = LO_TAB[idx];
			lk_d.lo.neg  = lo_delta[ACC_W];
			lk_d.lo.mag  = lo_abs[MAG_W-1:0];
			lk_d.d       = D_W'(mach - BP_TAB[idx]);
			lk_d.rcp     = RCP_TAB[idx];
		end
	end

	assign ready_o = !v_s1 || ready_i;

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_o) begin
			v_s1 <= valid_i;
		end
	end

	// stage 1 data
	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			lk_s1 <= lk_d;
		end
	end

	assign valid_o = v_s1;
	assign word_o  = lk_s1;
endmodule

// File: design/msal_interp.sv
// three-stage interpolation: weight product, slope product, rounding
`timescale 1ns / 1ps

module msal_interp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_i,
	output logic                ready_o,
	input  msal_pkg::lk_word_t  word_i,
	output logic                valid_o,
	input  logic                ready_i,
	output msal_pkg::lim_word_t word_o
);
	import msal_pkg::*;

	// product of one limit slope, carried between stages 3 and 4
	typedef struct packed {
		acc_t              base;
		logic              neg;
		logic [PROD_W-1:0] prod;
	} lim_prod_t;

	typedef struct packed {
		lim_seg_t        up;
		lim_seg_t        lo;
		logic [DR_W-1:0] dr;
		acc_t            cmd;
	} dr_word_t;

	typedef struct packed {
		lim_prod_t up;
		lim_prod_t lo;
		acc_t      cmd;
	} prod_word_t;

	logic [D_W+RCP_W-1:0] dr_full;
	logic       en2;
	logic       en3;
	logic       en4;
	logic       v_s2;
	logic       v_s3;
	logic       v_s4;
	dr_word_t   w_s2;
	prod_word_t w_s3;
	lim_word_t  w_s4;

	// base plus slope product scaled down, ties away from zero
	function automatic acc_t round_add(input lim_prod_t p);
		logic [PROD_W:0]   sum;
		logic [ACC_W:0]    r;
		logic [ACC_W:0]    v;
		logic [ACC_W:0]    tot;
		sum = {1'b0, p.prod} + ((PROD_W+1)'(1) << (FRAC_SH - 1));
		r   = (ACC_W+1)'(sum[PROD_W:FRAC_SH]);
		v   = p.neg ? -r : r;
		tot = {p.base[ACC_W-1], p.base} + v;
		return tot[ACC_W-1:0];
	endfunction

	// stall chain, each stage fills when it is empty or moves on
	assign en4 = !v_s4 || ready_i;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign ready_o = en2;

	assign dr_full = word_i.d * word_i.rcp;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en2) begin
				v_s2 <= valid_i;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// stage 2: offset in the segment times reciprocal
	always_ff @(posedge clk) begin
		if (en2 && valid_i) begin
			w_s2.up  <= word_i.up;
			w_s2.lo  <= word_i.lo;
			w_s2.dr  <= dr_full[DR_W-1:0];
			w_s2.cmd <= word_i.cmd;
		end
	end

	// stage 3: weight times slope magnitude for both limits
	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			w_s3.up.base <= w_s2.up.base;
			w_s3.up.neg  <= w_s2.up.neg;
			w_s3.up.prod <= w_s2.up.mag * w_s2.dr;
			w_s3.lo.base <= w_s2.lo.base;
			w_s3.lo.neg  <= w_s2.lo.neg;
			w_s3.lo.prod <= w_s2.lo.mag * w_s2.dr;
			w_s3.cmd     <= w_s2.cmd;
		end
	end

	// stage 4: round and add to the segment base
	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			w_s4.upper <= round_add(w_s3.up);
			w_s4.lower <= round_add(w_s3.lo);
			w_s4.cmd   <= w_s3.cmd;
		end
	end

	assign valid_o = v_s4;
	assign word_o  = w_s4;
endmodule

// File: design/msal_clamp.sv
// clamp stage and result register
`timescale 1ns / 1ps

module msal_clamp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_i,
	output logic                ready_o,
	input  msal_pkg::lim_word_t word_i,
	output logic                valid_o,
	input  logic                ready_i,
	output msal_pkg::acc_t      res_o
);
	import msal_pkg::*;

	acc_t res_d;
	logic v_s5;
	acc_t res_s5;

	// command held between lower and upper limit
	always_comb begin
		if (word_i.cmd > word_i.upper) begin
			res_d = word_i.upper;
		end else if (word_i.cmd < word_i.lower) begin
			res_d = word_i.lower;
		end else begin
			res_d = word_i.cmd;
		end
	end

	assign ready_o = !v_s5 || ready_i;

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (ready_o) begin
			v_s5 <= valid_i;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			res_s5 <= res_d;
		end
	end

	assign valid_o = v_s5;
	assign res_o   = res_s5;
endmodule

// File: design/mach_scheduled_accel_limiter.sv
// top level of the mach scheduled pitch acceleration limiter
// Usage:
//   sample channel: one word per item, a Q2.14 mach number and a Q8.8 signed
//   pitch acceleration command; taken when valid and ready are both high.
//   result channel: one Q8.8 word per sample, the command clamped to upper
//   and lower limits interpolated from a six-point mach table.
//   The sample passes through registered lookup, weight multiply, slope multiply,
//   rounding and clamp register stages before the result is valid.
//   Throughput: one sample per cycle while the receiver does not stall; the two
//   multiply stages are fully pipelined.
//   When the receiver stalls, empty stages keep filling, so up to five words
//   are held before sample.ready drops; nothing is lost or repeated.
//   Reset (arst_n low) empties the pipeline at once; tables are constants
//   and there is nothing to configure.
`timescale 1ns / 1ps
`include "mach_scheduled_accel_limiter_defines.svh"

module mach_scheduled_accel_limiter (
	input  logic     clk,
	input  logic     arst_n,
	msal_in_if.sink  sample,
	msal_out_if.source result
);
	import msal_pkg::*;

	logic      lk_valid;
	logic      lk_ready;
	lk_word_t  lk_word;
	logic      lim_valid;
	logic      lim_ready;
	lim_word_t lim_word;

	// segment lookup
	msal_lookup u_lookup (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (sample.valid),
		.ready_o (sample.ready),
		.mach    (sample.mach),
		.cmd     (sample.pitch_accel),
		.valid_o (lk_valid),
		.ready_i (lk_ready),
		.word_o  (lk_word)
	);

	// limit interpolation
	msal_interp u_interp (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (lk_valid),
		.ready_o (lk_ready),
		.word_i  (lk_word),
		.valid_o (lim_valid),
		.ready_i (lim_ready),
		.word_o  (lim_word)
	);

	// clamp and result register
	msal_clamp u_clamp (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (lim_valid),
		.ready_o (lim_ready),
		.word_i  (lim_word),
		.valid_o (result.valid),
		.ready_i (result.ready),
		.res_o   (result.limited_accel)
	);

	// checks
	`MSAL_ASSERT_NEXT(a_take_fills_s1, clk, arst_n, sample.valid && sample.ready, lk_valid)
	`MSAL_ASSERT_NOW(a_lim_order, clk, arst_n, lim_valid, lim_word.lower <= lim_word.upper)
	`MSAL_ASSERT_NOW(a_res_bound, clk, arst_n, result.valid,
		(result.limited_accel <= LIM_MAX) && (result.limited_accel >= LIM_MIN))
endmodule

// File: tb/sv/tb_mach_scheduled_accel_limiter.sv
// testbench for the mach scheduled acceleration limiter: scoreboard against a local clamp predictor
`timescale 1ns / 1ps

module tb_mach_scheduled_accel_limiter;

	localparam int NPTS           = 6;
	localparam int RANDOM_WORDS   = 525;
	localparam int TAIL_WORDS     = 60;
	localparam int HOLD_AT        = 200;
	localparam int HOLD_CYCLES    = 90;
	localparam int DRAIN_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 2000;

	// breakpoints in Q2.14, limits in Q8.8
	localparam longint BRK [NPTS] = '{6554, 9830, 13107, 15565, 17203, 18022};
	localparam longint UPL [NPTS] = '{128, 512, 768, 2560, 3072, 3840};
	localparam longint LOL [NPTS] = '{-77, -256, -512, -2048, -2560, -3328};

	typedef struct {
		logic        [15:0] mach;
		logic signed [15:0] accel;
	} sample_word_t;

	logic clk;
	logic arst_n;

	msal_in_if  sample_if ();
	msal_out_if result_if ();

	mach_scheduled_accel_limiter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_if.sink),
		.result (result_if.source)
	);

	sample_word_t       pending [$];
	logic signed [15:0] accel_expected [$];

	int   words_in;
	int   words_out;
	int   mismatches;
	int   idle_cycles;
	int   send_gap;
	int   send_rate;
	int   recv_stall;
	int   recv_rate;
	int   hold_left;
	logic hold_done;
	logic hold_on;
	logic tail_phase;

	// one limit between two table entries, rounded to nearest with ties away from zero
	function automatic longint lerp_limit(longint a, longint b, longint d, longint rcp);
		longint mag;
		longint r;
		mag = (b >= a) ? b - a : a - b;
		r = (mag * d * rcp + (longint'(1) << 29)) >>> 30;
		return (b >= a) ? a + r : a - r;
	endfunction

	// command clamped to the limits scheduled at this mach number
	function automatic logic signed [15:0] clamped_accel(logic [15:0] mach,
			logic signed [15:0] cmd);
		longint m;
		longint up;
		longint lo;
		longint gap;
		longint rcp;
		int     seg;
		m = longint'(mach);
		if (m <= BRK[0]) begin
			up = UPL[0];
			lo = LOL[0];
		end else if (m >= BRK[NPTS-1]) begin
			up = UPL[NPTS-1];
			lo = LOL[NPTS-1];
		end else begin
			seg = 0;
			for (int i = 0; i < NPTS - 1; i++)
				if (BRK[i] <= m) seg = i;
			gap = BRK[seg+1] - BRK[seg];
			rcp = ((longint'(1) << 30) + gap / 2) / gap;
			up = lerp_limit(UPL[seg], UPL[seg+1], m - BRK[seg], rcp);
			lo = lerp_limit(LOL[seg], LOL[seg+1], m - BRK[seg], rcp);
		end
		if (longint'(cmd) > up) return up[15:0];
		else if (longint'(cmd) < lo) return lo[15:0];
		else return cmd;
	endfunction

	task automatic report_mismatch(string what, logic signed [15:0] got,
			logic signed [15:0] want);
		mismatches++;
		$display("MISMATCH @%0t word %0d: %s got %0d expected %0d",
			$realtime, words_out, what, got, want);
	endtask

	task automatic queue_word(logic [15:0] m, logic signed [15:0] a);
		sample_word_t w;
		w.mach = m;
		w.accel = a;
		pending.push_back(w);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// sample driver, fed from the pending queue
	always @(posedge clk) begin
		sample_word_t w;
		logic         give;
		if (arst_n) begin
			if (sample_if.valid && sample_if.ready) begin
				accel_expected.push_back(clamped_accel(sample_if.mach, sample_if.pitch_accel));
				words_in <= words_in + 1;
			end
			if (!sample_if.valid || sample_if.ready) begin
				give = 1'b0;
				if (send_gap > 0)
					send_gap--;
				else if (pending.size() > 0) begin
					if (!tail_phase && !hold_on && $urandom_range(0, 15) < send_rate)
						send_gap = $urandom_range(0, 13);
					else
						give = 1'b1;
				end
				if (give) begin
					w = pending.pop_front();
					sample_if.mach <= w.mach;
					sample_if.pitch_accel <= w.accel;
				end
				sample_if.valid <= give;
			end
			tail_phase <= (pending.size() < TAIL_WORDS);
			// change the idling density now and then, zero gives stretches with none
			if ($urandom_range(0, 79) == 0) send_rate = $urandom_range(0, 5);
		end
	end

	// result receiver with random stalls and one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else if (!hold_done && words_in >= HOLD_AT) begin
				hold_left = HOLD_CYCLES - 1;
				hold_done = 1'b1;
				result_if.ready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				result_if.ready <= 1'b0;
			end else if (!tail_phase && $urandom_range(0, 15) < recv_rate) begin
				recv_stall = $urandom_range(0, 13);
				result_if.ready <= 1'b0;
			end else
				result_if.ready <= 1'b1;
			hold_on <= (hold_left > 0) || (!hold_done && words_in >= HOLD_AT);
			if ($urandom_range(0, 79) == 0) recv_rate = $urandom_range(0, 5);
		end
	end

	// result monitor and scoreboard
	always @(posedge clk) begin
		logic signed [15:0] want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (accel_expected.size() == 0)
				report_mismatch("unexpected word, limited_accel", result_if.limited_accel, 16'sd0);
			else begin
				want = accel_expected.pop_front();
				if (result_if.limited_accel !== want)
					report_mismatch("limited_accel", result_if.limited_accel, want);
			end
			words_out <= words_out + 1;
		end
	end

	// cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	// stimulus, reset and end of run
	initial begin
		logic [15:0]        m;
		logic signed [15:0] a;
		arst_n = 1'b0;
		sample_if.valid = 1'b0;
		sample_if.mach = '0;
		sample_if.pitch_accel = '0;
		result_if.ready = 1'b0;
		words_in = 0;
		words_out = 0;
		mismatches = 0;
		idle_cycles = 0;
		send_gap = 0;
		send_rate = 3;
		recv_stall = 0;
		recv_rate = 3;
		hold_left = 0;
		hold_done = 1'b0;
		hold_on = 1'b0;
		tail_phase = 1'b0;

		// table ends, breakpoints exactly and one off, segment midpoints, field extremes
		queue_word(16'd0, 16'sd32767);
		queue_word(16'd0, -16'sd32768);
		queue_word(16'd0, 16'sd100);
		queue_word(16'd6553, 16'sd128);
		queue_word(16'd6554, -16'sd77);
		queue_word(16'd6555, 16'sd32767);
		queue_word(16'd8192, -16'sd32768);
		queue_word(16'd9830, 16'sd32767);
		queue_word(16'd11468, -16'sd32768);
		queue_word(16'd13107, 16'sd32767);
		queue_word(16'd14336, -16'sd32768);
		queue_word(16'd15565, -16'sd32768);
		queue_word(16'd16384, 16'sd32767);
		queue_word(16'd16384, -16'sd1000);
		queue_word(16'd17203, 16'sd32767);
		queue_word(16'd17612, -16'sd32768);
		queue_word(16'd18021, 16'sd32767);
		queue_word(16'd18022, -16'sd32768);
		queue_word(16'd18023, 16'sd3840);
		queue_word(16'd65535, 16'sd32767);
		queue_word(16'd65535, -16'sd32768);
		queue_word(16'd65535, 16'sd0);
		queue_word(16'd12000, -16'sd1);

		// random words, weighted toward the interpolated range and the limit band
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: m = 16'($urandom_range(6000, 19000));
				6, 7:             m = 16'($urandom);
				8:                m = 16'(BRK[$urandom_range(0, NPTS - 1)]);
				default:          m = 16'(BRK[$urandom_range(0, NPTS - 1)]
					+ $urandom_range(0, 4) - 2);
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: a = 16'($urandom_range(0, 8191) - 4096);
				5, 6, 7:       a = 16'($urandom);
				default:       a = 16'($urandom_range(0, 799) - 400);
			endcase
			queue_word(m, a);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all words to be taken and all results to arrive
		do @(negedge clk); while (pending.size() != 0 || sample_if.valid);
		while (accel_expected.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
